// ----- rtl/core/sobel_pkg.sv -----
`timescale 1ns / 1ps

package sobel_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 11;
    localparam int MIN_SIZE       = 3;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_CMD_DEPTH  = 4;

    // squared magnitudes at or above 255^2 saturate
    localparam int SAT_LIMIT = 65025;
    localparam logic [PIX_W-1:0] SAT_VALUE = 8'hFF;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // per-item control handed from the front to the back
    typedef struct packed {
        logic wr;       // pixel item: update both line stores
        logic rd_up;    // use upper store read, else zero
        logic rd_mid;   // use middle store read, else zero
        logic emit;     // item produces a result
        logic border;   // result is the centre pixel unchanged
        logic last;     // result closes the frame
    } cmd_flags_t;

    localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

// ----- rtl/core/sobel_front.sv -----
`timescale 1ns / 1ps

module sobel_front
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ADDR_W     = $clog2(MAX_WIDTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,
    input  logic               s_tuser,
    input  logic               fifo_full,
    output logic               push,
    output logic [ADDR_W-1:0]  cmd_addr,
    output cmd_flags_t         cmd_flags,
    output logic [PIX_W-1:0]   cmd_pix
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [COL_W-1:0] col_reg, col_next, col_inc;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             draining;
    logic             ignore;
    logic             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(WIDTH_RESET);
            height_cfg_reg <= CFG_W'(HEIGHT_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            w_eff = COL_W'(MAX_WIDTH);
        else if (width_cfg_reg < CFG_W'(MIN_SIZE))
            w_eff = COL_W'(MIN_SIZE);
        else
            w_eff = COL_W'(width_cfg_reg);

        if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
            h_eff = ROW_W'(MAX_HEIGHT);
        else if (height_cfg_reg < CFG_W'(MIN_SIZE))
            h_eff = ROW_W'(MIN_SIZE);
        else
            h_eff = ROW_W'(height_cfg_reg);
    end

    // all pixels of the frame are in once the row count reaches the height
    assign draining = (row_reg >= h_eff);
    // a flush before the drain does nothing
    assign ignore   = s_tuser && !draining;
    assign s_tready = !fifo_full;
    assign take     = s_tvalid && s_tready && !ignore;
    assign push     = take;
    assign cmd_addr = col_reg[ADDR_W-1:0];

    always_comb
    begin
        cmd_flags = '0;
        if (!draining)
        begin
            cmd_flags.wr     = 1'b1;
            cmd_flags.rd_up  = (row_reg >= ROW_W'(2));
            cmd_flags.rd_mid = (row_reg >= ROW_W'(1));
            cmd_flags.emit   = (row_reg >= ROW_W'(2))
                               || (row_reg == ROW_W'(1) && col_reg >= COL_W'(1));
            cmd_pix          = s_tdata;
        end
        else
        begin
            cmd_flags.rd_up  = (col_reg < w_eff);
            cmd_flags.rd_mid = (col_reg < w_eff);
            cmd_flags.emit   = 1'b1;
            cmd_flags.last   = (col_reg >= w_eff);
            cmd_pix          = '0;
        end
        // output sits one column back; first/last column, top row and drain row
        cmd_flags.border = (col_reg <= COL_W'(1)) || (col_reg >= w_eff)
                           || (row_reg == ROW_W'(1)) || draining;
    end

    always_comb
    begin
        col_inc  = col_reg + COL_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (cmd_flags.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (!draining && col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/core/sobel_cmd_fifo.sv -----
`timescale 1ns / 1ps

module sobel_cmd_fifo
    import sobel_pkg::*;
#(
    parameter int DEPTH  = DEF_CMD_DEPTH,
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue count out of range");

endmodule

// ----- rtl/core/sobel_back.sv -----
`timescale 1ns / 1ps

module sobel_back
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH),
    parameter int CMD_W     = ADDR_W + FLAGS_W + PIX_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] cmd_data,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_GRAD,
        S_SQ,
        S_SUM,
        S_ROOT,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_q_reg, mid_q_reg;

    logic [PIX_W-1:0] win_reg [3][3];

    logic [ADDR_W-1:0] head_addr;
    cmd_flags_t        head_flags;
    logic [PIX_W-1:0]  head_pix;

    logic [ADDR_W-1:0] addr_reg;
    cmd_flags_t        flags_reg;
    logic [PIX_W-1:0]  pix_reg;

    logic [PIX_W-1:0]  top_val, mid_val;
    logic              mem_wr;

    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0] gx_next, gy_next;
    logic signed [10:0] gx_reg, gy_reg;
    logic signed [21:0] gx_ext, gy_ext, prod_x, prod_y;
    logic [19:0]        sq_x_reg, sq_y_reg;
    logic [20:0]        sum_next, sum_reg;

    logic [2:0]         root_bit_reg;
    logic [PIX_W-1:0]   root_reg, root_try;
    logic [15:0]        root_sq;

    logic [PIX_W-1:0]   result_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_last_reg;
    logic               out_free;

    assign {head_addr, head_flags, head_pix} = cmd_data;
    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty;

    assign top_val = flags_reg.rd_up  ? up_q_reg  : '0;
    assign mid_val = flags_reg.rd_mid ? mid_q_reg : '0;
    assign mem_wr  = (state_reg == S_SHIFT) && flags_reg.wr;

    // read on pop, write back in the next cycle at the same column
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            upper_mem[addr_reg]  <= mid_val;
            middle_mem[addr_reg] <= pix_reg;
        end
        if (cmd_pop)
        begin
            up_q_reg  <= upper_mem[head_addr];
            mid_q_reg <= middle_mem[head_addr];
        end
    end

    // window after the shift
    always_comb
    begin
        gx_pos  = {2'b00, win_reg[0][0]} + {1'b0, win_reg[1][0], 1'b0} + {2'b00, win_reg[2][0]};
        gx_neg  = {2'b00, win_reg[0][2]} + {1'b0, win_reg[1][2], 1'b0} + {2'b00, win_reg[2][2]};
        gy_pos  = {2'b00, win_reg[0][0]} + {1'b0, win_reg[0][1], 1'b0} + {2'b00, win_reg[0][2]};
        gy_neg  = {2'b00, win_reg[2][0]} + {1'b0, win_reg[2][1], 1'b0} + {2'b00, win_reg[2][2]};
        gx_next = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy_next = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    assign gx_ext   = 22'(gx_reg);
    assign gy_ext   = 22'(gy_reg);
    assign prod_x   = gx_ext * gx_ext;
    assign prod_y   = gy_ext * gy_ext;
    assign sum_next = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    // one result bit per step, top down
    assign root_try = root_reg | (PIX_W'(1) << root_bit_reg);
    assign root_sq  = 16'(root_try) * 16'(root_try);

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            flags_reg     <= '0;
            pix_reg       <= '0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            sq_x_reg      <= '0;
            sq_y_reg      <= '0;
            sum_reg       <= '0;
            root_bit_reg  <= '0;
            root_reg      <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    win_reg[r][k] <= '0;
            end
        end
        else
        begin
            // in S_OUT the output register is either reloaded or held
            if (m_tready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        addr_reg  <= head_addr;
                        flags_reg <= head_flags;
                        pix_reg   <= head_pix;
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= top_val;
                    win_reg[1][2] <= mid_val;
                    win_reg[2][2] <= pix_reg;
                    // the new centre is the old right-hand middle tap
                    result_reg    <= win_reg[1][2];
                    if (!flags_reg.emit)
                        state_reg <= S_IDLE;
                    else if (flags_reg.border)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_GRAD;
                end
                S_GRAD:
                begin
                    gx_reg    <= gx_next;
                    gy_reg    <= gy_next;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sq_x_reg  <= prod_x[19:0];
                    sq_y_reg  <= prod_y[19:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg <= sum_next;
                    if (sum_next >= 21'(SAT_LIMIT))
                    begin
                        result_reg <= SAT_VALUE;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        root_reg     <= '0;
                        root_bit_reg <= 3'(PIX_W - 1);
                        state_reg    <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (root_sq <= sum_reg[15:0])
                    begin
                        root_reg   <= root_try;
                        result_reg <= root_try;
                    end
                    else
                    begin
                        result_reg <= root_reg;
                    end
                    if (root_bit_reg == '0)
                        state_reg <= S_OUT;
                    else
                        root_bit_reg <= root_bit_reg - 3'(1);
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= result_reg;
                        out_last_reg  <= flags_reg.last;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_root_unsaturated: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> (sum_reg < 21'(SAT_LIMIT)))
        else $error("root started on saturated sum");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output state");

endmodule

// ----- rtl/core/sobel_edge_magnitude_top.sv -----
`timescale 1ns / 1ps
// Sobel 3x3 edge magnitude over a raster pixel stream.
// Each accepted item is classified in the front and queued; the back takes one
// command at a time: line store read and window shift, after which a silent
// item ends, a border pixel goes to output, and others run gradient, squares
// and sum, then output if saturated or after an 8-step root; output can stall.
// Results lag inputs by frame width + 1 items; a 4-deep queue absorbs bursts.
// rst_n (async, active low) clears counters, window and queue, and sets size registers to 640x480.

module sobel_edge_magnitude_top
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int CMD_DEPTH  = DEF_CMD_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel_in
    input  logic [0:0]       s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] edge_value
    output logic             m_tlast
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CMD_W  = ADDR_W + FLAGS_W + PIX_W;

    logic              push, pop, fifo_full, fifo_empty;
    logic [ADDR_W-1:0] cmd_addr;
    cmd_flags_t        cmd_flags;
    logic [PIX_W-1:0]  cmd_pix;
    logic [CMD_W-1:0]  wr_cmd, rd_cmd;

    assign cfg_ready = 1'b1;
    assign wr_cmd    = {cmd_addr, cmd_flags, cmd_pix};

    sobel_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd_addr  (cmd_addr),
        .cmd_flags (cmd_flags),
        .cmd_pix   (cmd_pix)
    );

    sobel_cmd_fifo #(
        .DEPTH  (CMD_DEPTH),
        .DATA_W (CMD_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_cmd),
        .pop     (pop),
        .rd_data (rd_cmd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    sobel_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W),
        .CMD_W     (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (rd_cmd),
        .cmd_empty (fifo_empty),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
